// ----- rtl/spi_eep_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_eep_pkg
// Shared constants, item and result types for the serial EEPROM device model.
// ----------------------------------------------------------------------------
package spi_eep_pkg;

  // Memory geometry (powers of two)
  localparam int unsigned MEM_BYTES  = 32768;
  localparam int unsigned PAGE_BYTES = 64;
  localparam int unsigned ADDR_W     = $clog2(MEM_BYTES);
  localparam int unsigned PAGE_W     = $clog2(PAGE_BYTES);

  // Protection boundaries
  localparam int unsigned PROT_QUARTER = MEM_BYTES - MEM_BYTES / 4;
  localparam int unsigned PROT_HALF    = MEM_BYTES / 2;

  // Item kinds
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  // Opcodes
  localparam logic [7:0] OP_WRSR  = 8'h01;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WREN  = 8'h06;

  // Block protect codes
  localparam logic [1:0] BP_NONE    = 2'd0;
  localparam logic [1:0] BP_QUARTER = 2'd1;
  localparam logic [1:0] BP_HALF    = 2'd2;
  localparam logic [1:0] BP_ALL     = 2'd3;

  // Frame phases
  localparam logic [2:0] PH_OPCODE     = 3'd0;
  localparam logic [2:0] PH_ADDR_HI    = 3'd1;
  localparam logic [2:0] PH_ADDR_LO    = 3'd2;
  localparam logic [2:0] PH_DATA       = 3'd3;
  localparam logic [2:0] PH_STATUS_OUT = 3'd4;
  localparam logic [2:0] PH_STATUS_IN  = 3'd5;
  localparam logic [2:0] PH_IGNORE     = 3'd6;

  localparam logic [15:0] WCT_RESET  = 16'd5000;
  localparam logic [7:0]  ERASED     = 8'hFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] mosi_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] miso_byte;
    logic       write_in_progress;
    logic       write_enabled;
  } result_t;

endpackage

// ----- rtl/spi_eep_ram.sv -----
// ----------------------------------------------------------------------------
// spi_eep_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spi_eep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/spi_eeprom_device_model.sv -----
// ----------------------------------------------------------------------------
// spi_eeprom_device_model
// Behavioural serial EEPROM slave (25xx family) driven one transaction a time.
// ----------------------------------------------------------------------------
// Each transaction is an exchanged SPI byte, a chip-select release or one time
// tick, presented on item_i and taken when start is high while busy is low.
// Every transaction returns exactly one result on result_o, shown for a single
// cycle with strobe_o high; the receiver cannot stall it. A transaction first
// launches the read of the cell memory at the current address, then acts on
// the returned byte and updates the state in its execute cycle; the result
// appears in the cycle after that, during which the next transaction may
// already be taken. After reset the block erases the whole cell memory to 0xFF,
// one byte a cycle, holding busy high until done; the write_cycle_ticks register
// can be written over the APB port throughout. The user must write configuration
// only while no transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module spi_eeprom_device_model (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // transaction port
  input  logic                 start,
  output logic                 busy,
  input  spi_eep_pkg::item_t   item_i,
  output logic                 strobe_o,
  output spi_eep_pkg::result_t result_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import spi_eep_pkg::*;

  // Erase pass
  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // Transaction flow
  logic    exec_q;
  item_t   item_q;
  logic    strobe_q;
  result_t result_q, result_d;

  // Device state
  logic              wel_q, wel_d;
  logic [1:0]        bp_q, bp_d;
  logic              srwd_q, srwd_d;
  logic [15:0]       ticks_q, ticks_d;
  logic [2:0]        phase_q, phase_d;
  logic [7:0]        opcode_q, opcode_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              pend_q, pend_d;
  logic [15:0]       wct_q;

  // Memory port
  logic              mem_we, prog_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic              accept;
  logic              is_prot;
  logic [15:0]       addr_hi;

  assign accept = start && !busy;
  assign busy   = clr_q || exec_q;

  // ---------------------------------------------------------------------------
  // Configuration: one register, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = {16'd0, wct_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wct_q <= WCT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      wct_q <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Cell memory
  // ---------------------------------------------------------------------------
  spi_eep_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  // Erase pass owns the write port until it finishes; a data byte is
  // programmed only in its execute cycle
  assign mem_we    = clr_q || (exec_q && prog_we);
  assign mem_waddr = clr_q ? clr_addr_q : addr_q;
  assign mem_wdata = clr_q ? ERASED : item_q.mosi_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Block protection of the current address
  // ---------------------------------------------------------------------------
  always_comb begin
    case (bp_q)
      BP_NONE:    is_prot = 1'b0;
      BP_QUARTER: is_prot = (32'(addr_q) >= PROT_QUARTER);
      BP_HALF:    is_prot = (32'(addr_q) >= PROT_HALF);
      BP_ALL:     is_prot = 1'b1;
      default:    is_prot = 1'b0;
    endcase
  end

  assign addr_hi = {item_q.mosi_byte, 8'h00};

  // ---------------------------------------------------------------------------
  // Execute step: act on the latched transaction with the read data in hand
  // ---------------------------------------------------------------------------
  always_comb begin
    wel_d    = wel_q;
    bp_d     = bp_q;
    srwd_d   = srwd_q;
    ticks_d  = ticks_q;
    phase_d  = phase_q;
    opcode_d = opcode_q;
    addr_d   = addr_q;
    pend_d   = pend_q;
    prog_we  = 1'b0;
    result_d = '0;

    case (item_q.func)
      FUNC_BYTE: begin
        case (phase_q)
          PH_OPCODE: begin
            opcode_d = item_q.mosi_byte;
            if (ticks_q != 16'd0 && item_q.mosi_byte != OP_RDSR) begin
              phase_d = PH_IGNORE;
            end else if (item_q.mosi_byte == OP_READ || item_q.mosi_byte == OP_WRITE) begin
              phase_d = PH_ADDR_HI;
            end else if (item_q.mosi_byte == OP_RDSR) begin
              phase_d = PH_STATUS_OUT;
            end else if (item_q.mosi_byte == OP_WRSR) begin
              phase_d = wel_q ? PH_STATUS_IN : PH_IGNORE;
            end else if (item_q.mosi_byte == OP_WREN) begin
              wel_d   = 1'b1;
              phase_d = PH_IGNORE;
            end else if (item_q.mosi_byte == OP_WRDI) begin
              wel_d   = 1'b0;
              phase_d = PH_IGNORE;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
          PH_ADDR_HI: begin
            addr_d  = addr_hi[ADDR_W-1:0];
            phase_d = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            addr_d  = addr_q | ADDR_W'(item_q.mosi_byte);
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            if (opcode_q == OP_READ) begin
              result_d.miso_byte = mem_rdata;
              addr_d = addr_q + ADDR_W'(1);
            end else begin
              prog_we = wel_q && !is_prot;
              if (prog_we) begin
                pend_d = 1'b1;
              end
              // wrap inside the page
              addr_d = {addr_q[ADDR_W-1:PAGE_W], addr_q[PAGE_W-1:0] + PAGE_W'(1)};
            end
          end
          PH_STATUS_OUT: begin
            result_d.miso_byte = {srwd_q, 3'b000, bp_q, wel_q, (ticks_q != 16'd0)};
          end
          PH_STATUS_IN: begin
            srwd_d  = item_q.mosi_byte[7];
            bp_d    = item_q.mosi_byte[3:2];
            pend_d  = 1'b1;
            phase_d = PH_IGNORE;
          end
          default: begin
          end
        endcase
      end
      FUNC_RELEASE: begin
        if (pend_q) begin
          ticks_d = wct_q;
          wel_d   = 1'b0;
          pend_d  = 1'b0;
        end
        phase_d = PH_OPCODE;
      end
      FUNC_TICK: begin
        if (ticks_q != 16'd0) begin
          ticks_d = ticks_q - 16'd1;
        end
      end
      default: begin
      end
    endcase

    result_d.write_in_progress = (ticks_d != 16'd0);
    result_d.write_enabled     = wel_d;
  end

  // Hold the transaction for the execute cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q   <= 1'b0;
      strobe_q <= 1'b0;
      result_q <= '0;
      wel_q    <= 1'b0;
      bp_q     <= BP_NONE;
      srwd_q   <= 1'b0;
      ticks_q  <= 16'd0;
      phase_q  <= PH_OPCODE;
      opcode_q <= 8'd0;
      addr_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      exec_q   <= accept;
      strobe_q <= exec_q;
      if (exec_q) begin
        result_q <= result_d;
        wel_q    <= wel_d;
        bp_q     <= bp_d;
        srwd_q   <= srwd_d;
        ticks_q  <= ticks_d;
        phase_q  <= phase_d;
        opcode_q <= opcode_d;
        addr_q   <= addr_d;
        pend_q   <= pend_d;
      end
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

// ----- rtl/spi_eep_chk.sv -----
// ----------------------------------------------------------------------------
// spi_eep_chk
// Port-level timing checks for the serial EEPROM device model.
// ----------------------------------------------------------------------------
module spi_eep_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 strobe_o,
  input spi_eep_pkg::result_t result_o
);

  import spi_eep_pkg::*;

  // A taken transaction blocks the port for its execute cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transaction was taken");

  // Each taken transaction returns its result once its execute cycle is over
  a_result_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 strobe_o)
    else $error("result missing two cycles after a transaction");

  // Results never come back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("two results in consecutive cycles");

  // A result only follows an execute cycle and frees the port
  a_strobe_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ($past(busy) && !busy))
    else $error("result without a preceding execute cycle");

  // Hold the result ports steady between transactions
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!strobe_o && !$past(strobe_o)) |-> $stable(result_o))
    else $error("result changed without a transaction");

endmodule

bind spi_eeprom_device_model spi_eep_chk u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .result_o (result_o)
);
